// File: sv/mlhts_pkg.sv
// Package for the mask-layer HBM / TE-sync block.
// Holds word types, codes, FSM state type, command/status structs and timing constants.
// No dependencies.
package mlhts_pkg;

   localparam int TIME_BITS_DEFAULT = 24;
   localparam int SCALE_SHIFT       = 31;
   localparam int CSR_IDX_W         = 3;

   localparam logic [14:0] TE60  = 15'd16667;
   localparam logic [14:0] TE90  = 15'd11111;
   localparam logic [14:0] TE120 = 15'd8334;

   localparam logic [31:0] RECIP60  =
      32'(((64'd1 << SCALE_SHIFT) * 64'(TE60) + 64'(TE60) - 64'd1) / 64'(TE60));
   localparam logic [31:0] RECIP90  =
      32'(((64'd1 << SCALE_SHIFT) * 64'(TE90) + 64'(TE60) - 64'd1) / 64'(TE60));
   localparam logic [31:0] RECIP120 =
      32'(((64'd1 << SCALE_SHIFT) * 64'(TE120) + 64'(TE60) - 64'd1) / 64'(TE60));

   localparam logic [1:0] FPS_60  = 2'd0;
   localparam logic [1:0] FPS_90  = 2'd1;
   localparam logic [1:0] FPS_120 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FPS_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_THRESH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_THRESH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TE_PERIOD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_BEFORE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_AFTER  = 3'd5;

   typedef enum logic [1:0] {
      MASK_NONE      = 2'd0,
      MASK_COMMON    = 2'd1,
      MASK_SCREEN_ON = 2'd2,
      MASK_CIRCLE    = 2'd3
   } mask_type;

   typedef enum logic [2:0] {
      ACT_NONE            = 3'd0,
      ACT_ENTER_COMMON    = 3'd1,
      ACT_ENTER_SCREEN_ON = 3'd2,
      ACT_EXIT            = 3'd3,
      ACT_CIRCLE_ON       = 3'd4,
      ACT_CIRCLE_OFF      = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      SEL_LEFT   = 2'd0,
      SEL_RIGHT  = 2'd1,
      SEL_TE     = 2'd2,
      SEL_SETTLE = 2'd3
   } scale_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SCALE,
      ST_MLOAD,
      ST_MDIV,
      ST_SYNC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      mask_type    mask_state;
      logic [23:0] us_since_te;
      logic        backlight_active;
      logic        arm_screen_on;
   } req_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] sync_delay_us;
      logic [15:0] settle_delay_us;
      logic        flag_write;
      logic        max_backlight;
      logic        hbm_open;
   } rsp_type;

   typedef struct packed {
      logic          load_item;
      logic          classify;
      logic          scale_store;
      scale_sel_type scale_sel;
      logic          mod_load;
      logic          div_step;
      logic          sync_calc;
      logic          out_load;
   } cmd_type;

   typedef struct packed {
      logic needs_delay;
   } status_type;

   function automatic logic [31:0] te_recip(input logic [1:0] fps);
      logic [31:0] m;
      unique case (fps)
         FPS_90:  m = RECIP90;
         FPS_120: m = RECIP120;
         default: m = RECIP60;
      endcase
      return m;
   endfunction

endpackage

// File: sv/mlhts_ctrl.sv
// Controller FSM for the mask-layer HBM / TE-sync block.
// Sequences classify, four scalings, the TE phase modulo, the sync calculation and the output load.
// Depends on mlhts_pkg.
module mlhts_ctrl #(
   parameter int TIME_BITS = mlhts_pkg::TIME_BITS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  mlhts_pkg::status_type status,
   output mlhts_pkg::cmd_type   cmd
);
   import mlhts_pkg::*;

   localparam int CNT_W = $clog2(TIME_BITS);

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   scale_sel_type       idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            idx_in = SEL_LEFT;
            state_in = status.needs_delay ? ST_SCALE : ST_FINISH;
         end
         ST_SCALE: begin
            if (idx_ff == SEL_SETTLE) begin
               state_in = ST_MLOAD;
            end else begin
               idx_in   = scale_sel_type'(idx_ff + 2'd1);
            end
         end
         ST_MLOAD: begin
            cnt_in   = CNT_W'(TIME_BITS - 1);
            state_in = ST_MDIV;
         end
         ST_MDIV: begin
            if (cnt_ff == '0) state_in = ST_SYNC;
            else cnt_in = cnt_ff - 1'b1;
         end
         ST_SYNC: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.scale_sel   = idx_ff;
      cmd.load_item   = (state_ff == ST_IDLE) && req_valid;
      cmd.classify    = (state_ff == ST_CLASSIFY);
      cmd.scale_store = (state_ff == ST_SCALE);
      cmd.mod_load    = (state_ff == ST_MLOAD);
      cmd.div_step    = (state_ff == ST_MDIV);
      cmd.sync_calc   = (state_ff == ST_SYNC);
      cmd.out_load    = (state_ff == ST_FINISH) && out_free;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.out_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= SEL_LEFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result word overwritten while stalled");

   a_accept_to_classify: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid) |=> state_ff == ST_CLASSIFY)
      else $error("accepted word not classified");

   a_mdiv_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MDIV && cnt_ff == '0) |=> state_ff == ST_SYNC)
      else $error("modulo division did not end");

   a_scale_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCALE && idx_ff == SEL_SETTLE) |=> state_ff == ST_MLOAD)
      else $error("modulo not started after last scale");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MDIV) |-> cnt_ff <= CNT_W'(TIME_BITS - 1))
      else $error("modulo count out of range");

endmodule

// File: sv/mlhts_dp.sv
// Datapath for the mask-layer HBM / TE-sync block.
// Holds config, layer state, the scaling multiplier, the phase divider and result word.
// Depends on mlhts_pkg.
module mlhts_dp #(
   parameter int TIME_BITS = mlhts_pkg::TIME_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mlhts_pkg::req_type                    req_data,
   output mlhts_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [mlhts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [15:0]                           csr_wdata,
   input  mlhts_pkg::cmd_type                    cmd,
   output mlhts_pkg::status_type                 status
);
   import mlhts_pkg::*;

   localparam int PROD_W = SCALE_SHIFT + 16;

   logic [1:0]  fps_ff;
   logic [15:0] left_ff, right_ff, te_per_ff, dly_before_ff, dly_after_ff;

   mask_type    prev_ff, prev_in;
   logic        hbm_ff, hbm_in;
   logic        pend_ff, pend_in;

   mask_type             mask_ff;
   logic [TIME_BITS-1:0] since_ff;
   logic                 bl_ff, arm_ff;
   logic [31:0]          since_wide;

   action_type  cls, act_in, act_ff;
   logic        fw_in, mb_in, fw_ff, mb_ff;
   logic        pend_eff;

   logic [15:0] left_s_ff, right_s_ff, te_s_ff, settle_s_ff, te_eff;
   logic [15:0] src;
   logic [PROD_W-1:0] prod;
   logic [15:0] scaled;

   logic [15:0]          rem_ff, rem_in, div_ff;
   logic [TIME_BITS-1:0] dsh_ff, dsh_in;
   logic [16:0]          trial, diff;
   logic                 ge;

   logic [16:0] d17;
   logic [15:0] sync_ff, settle_out_ff;
   rsp_type     out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fps_ff        <= FPS_60;
         left_ff       <= '0;
         right_ff      <= '0;
         te_per_ff     <= 16'(TE60);
         dly_before_ff <= '0;
         dly_after_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FPS_MODE:     fps_ff        <= csr_wdata[1:0];
            CSR_LEFT_THRESH:  left_ff       <= csr_wdata;
            CSR_RIGHT_THRESH: right_ff      <= csr_wdata;
            CSR_TE_PERIOD:    te_per_ff     <= csr_wdata;
            CSR_DELAY_BEFORE: dly_before_ff <= csr_wdata;
            CSR_DELAY_AFTER:  dly_after_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign since_wide = {8'd0, req_data.us_since_te};

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         mask_ff  <= req_data.mask_state;
         since_ff <= since_wide[TIME_BITS-1:0];
         bl_ff    <= req_data.backlight_active;
         arm_ff   <= req_data.arm_screen_on;
      end
   end

   always_comb begin
      pend_eff = pend_ff || arm_ff;
      pend_in  = pend_eff;
      priority if (mask_ff == MASK_COMMON && prev_ff == MASK_NONE) begin
         cls = ACT_ENTER_COMMON;
      end else if (bl_ff && pend_eff && mask_ff == MASK_SCREEN_ON && prev_ff == MASK_NONE) begin
         cls     = ACT_ENTER_SCREEN_ON;
         pend_in = 1'b0;
      end else if (prev_ff != MASK_NONE && mask_ff == MASK_NONE) begin
         cls = ACT_EXIT;
      end else if (mask_ff == MASK_CIRCLE && prev_ff == MASK_SCREEN_ON) begin
         cls = ACT_CIRCLE_ON;
      end else if (mask_ff == MASK_SCREEN_ON && prev_ff == MASK_CIRCLE) begin
         cls = ACT_CIRCLE_OFF;
      end else begin
         cls = ACT_NONE;
      end
   end

   always_comb begin
      act_in = ACT_NONE;
      fw_in  = 1'b0;
      mb_in  = 1'b0;
      hbm_in = hbm_ff;
      priority if (!hbm_ff && (cls == ACT_ENTER_COMMON || cls == ACT_ENTER_SCREEN_ON)) begin
         act_in = cls;
         hbm_in = 1'b1;
         fw_in  = (cls == ACT_ENTER_COMMON);
         mb_in  = (cls == ACT_ENTER_COMMON);
      end else if (hbm_ff && cls == ACT_EXIT) begin
         act_in = ACT_EXIT;
         hbm_in = 1'b0;
         fw_in  = 1'b1;
      end else if (cls == ACT_CIRCLE_ON) begin
         act_in = ACT_CIRCLE_ON;
         fw_in  = 1'b1;
         mb_in  = 1'b1;
      end else if (cls == ACT_CIRCLE_OFF) begin
         act_in = ACT_CIRCLE_OFF;
         fw_in  = 1'b1;
      end else begin
         act_in = ACT_NONE;
      end
      prev_in = mask_ff;
   end

   assign status.needs_delay = (act_in == ACT_ENTER_COMMON) ||
                               (act_in == ACT_ENTER_SCREEN_ON) ||
                               (act_in == ACT_EXIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= MASK_NONE;
         hbm_ff  <= 1'b0;
         pend_ff <= 1'b0;
      end else if (cmd.classify) begin
         prev_ff <= prev_in;
         hbm_ff  <= hbm_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         act_ff <= act_in;
         fw_ff  <= fw_in;
         mb_ff  <= mb_in;
      end
   end

   always_comb begin
      unique case (cmd.scale_sel)
         SEL_LEFT:   src = left_ff;
         SEL_RIGHT:  src = right_ff;
         SEL_TE:     src = te_per_ff;
         SEL_SETTLE: src = (act_ff == ACT_EXIT) ? dly_after_ff : dly_before_ff;
         default:    src = left_ff;
      endcase
   end

   assign prod   = PROD_W'(src) * PROD_W'(te_recip(fps_ff));
   assign scaled = prod[PROD_W-1:SCALE_SHIFT];
   assign te_eff = (te_s_ff == '0) ? 16'(TE60) : te_s_ff;

   assign trial = {rem_ff, dsh_ff[TIME_BITS-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in = ge ? diff[15:0] : trial[15:0];
      dsh_in = {dsh_ff[TIME_BITS-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      priority if (cmd.mod_load) begin
         rem_ff <= '0;
         dsh_ff <= since_ff;
         div_ff <= te_eff;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dsh_ff <= dsh_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scale_store) begin
         unique case (cmd.scale_sel)
            SEL_LEFT:   left_s_ff   <= scaled;
            SEL_RIGHT:  right_s_ff  <= scaled;
            SEL_TE:     te_s_ff     <= scaled;
            SEL_SETTLE: settle_s_ff <= scaled;
            default: ;
         endcase
      end
   end

   always_comb begin
      priority if (rem_ff < left_s_ff) begin
         d17 = {1'b0, left_s_ff} - {1'b0, rem_ff};
      end else if (rem_ff > right_s_ff) begin
         d17 = {1'b0, te_eff} - {1'b0, rem_ff} + {1'b0, left_s_ff};
      end else begin
         d17 = '0;
      end
   end

   always_ff @(posedge clock) begin
      priority if (cmd.classify) begin
         sync_ff       <= '0;
         settle_out_ff <= '0;
      end else if (cmd.sync_calc) begin
         sync_ff       <= d17[16] ? 16'hFFFF : d17[15:0];
         settle_out_ff <= settle_s_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_ff.action          <= act_ff;
         out_ff.sync_delay_us   <= sync_ff;
         out_ff.settle_delay_us <= settle_out_ff;
         out_ff.flag_write      <= fw_ff;
         out_ff.max_backlight   <= mb_ff;
         out_ff.hbm_open        <= hbm_ff;
      end
   end

   assign rsp_data = out_ff;

endmodule

// File: sv/mask_layer_hbm_te_sync.sv
// Top level of the mask-layer HBM / TE-sync block.
// Instantiates mlhts_ctrl and mlhts_dp; depends on mlhts_pkg.
//
//  channel | ports                                   | direction
//  req     | req_valid, req_stall, req_data          | in, one frame event word
//  rsp     | rsp_valid, rsp_stall, rsp_data          | out, one result word per event
//  csr     | csr_valid, csr_ready, csr_index, wdata  | in, register write, always ready
//
// Events that neither enter nor exit HBM go from classify straight to the output load.
// Enter and exit run four scalings, then the one-bit-per-cycle restoring divider for the
// TE phase modulo, then the sync calculation before the output load.
// Synchronous active-high reset clears control, layer state and registers; no clearing pass.
// A new event is accepted while a finished result still waits on rsp_stall.
// A result that cannot be delivered holds the block before its next event.
module mask_layer_hbm_te_sync #(
   parameter int TIME_BITS = mlhts_pkg::TIME_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  mlhts_pkg::req_type              req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output mlhts_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mlhts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata
);
   import mlhts_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mlhts_ctrl #(
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   mlhts_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

// File: dv/mlhts_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the mask-layer HBM / TE-sync block: watches the csr, req and rsp channels,
// predicts each result word from its own copy of layer state and registers, and compares.
// Depends on mlhts_pkg for the word types, codes and timing constants.
module mlhts_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  mlhts_pkg::req_type              req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  mlhts_pkg::rsp_type              rsp_data,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [mlhts_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                     csr_wdata,
   input  logic                            end_check,
   output int                              errors,
   output int                              outstanding,
   output int                              checked
);
   import mlhts_pkg::*;

   typedef enum logic [2:0] {
      CHG_NONE,
      CHG_COMMON_ADD,
      CHG_SCREEN_ON_ADD,
      CHG_REMOVED,
      CHG_CIRCLE_ADD,
      CHG_CIRCLE_REMOVED
   } change_type;

   logic [1:0]  fps_mode;
   logic [15:0] left_thresh;
   logic [15:0] right_thresh;
   logic [15:0] te_period;
   logic [15:0] delay_before;
   logic [15:0] delay_after;

   mask_type    last_mask;
   logic        hbm_on;
   logic        screen_on_armed;
   logic        end_reported;

   rsp_type     expected_results[$];

   task automatic flag_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_error($sformatf("result %0d %s: got 0x%0h, want 0x%0h", checked, name, got, want));
   endtask

   function automatic longint unsigned scale_to_rate(input logic [15:0] t60);
      longint unsigned period;
      case (fps_mode)
         FPS_90:  period = longint'(TE90);
         FPS_120: period = longint'(TE120);
         default: period = longint'(TE60);
      endcase
      return (longint'(t60) * period) / longint'(TE60);
   endfunction

   function automatic logic [15:0] te_window_wait(input logic [23:0] since);
      longint unsigned left_us, right_us, period, phase, wait_us;
      left_us  = scale_to_rate(left_thresh);
      right_us = scale_to_rate(right_thresh);
      period   = scale_to_rate(te_period);
      if (period == 0)
         period = longint'(TE60);
      phase   = longint'(since) % period;
      wait_us = 0;
      if (phase < left_us)
         wait_us = left_us - phase;
      else if (phase > right_us)
         wait_us = period - phase + left_us;
      if (wait_us > 65535)
         wait_us = 65535;
      return wait_us[15:0];
   endfunction

   function automatic rsp_type next_result(input req_type ev);
      change_type kind;
      rsp_type    r;
      r    = '0;
      kind = CHG_NONE;
      if (ev.arm_screen_on)
         screen_on_armed = 1'b1;

      if (ev.mask_state == MASK_COMMON && last_mask == MASK_NONE) begin
         kind = CHG_COMMON_ADD;
      end else if (ev.backlight_active && screen_on_armed &&
                   ev.mask_state == MASK_SCREEN_ON && last_mask == MASK_NONE) begin
         screen_on_armed = 1'b0;
         kind = CHG_SCREEN_ON_ADD;
      end else if (last_mask != MASK_NONE && ev.mask_state == MASK_NONE) begin
         kind = CHG_REMOVED;
      end else if (ev.mask_state == MASK_CIRCLE && last_mask == MASK_SCREEN_ON) begin
         kind = CHG_CIRCLE_ADD;
      end else if (ev.mask_state == MASK_SCREEN_ON && last_mask == MASK_CIRCLE) begin
         kind = CHG_CIRCLE_REMOVED;
      end

      if (!hbm_on && (kind == CHG_COMMON_ADD || kind == CHG_SCREEN_ON_ADD)) begin
         r.action          = (kind == CHG_COMMON_ADD) ? ACT_ENTER_COMMON : ACT_ENTER_SCREEN_ON;
         r.sync_delay_us   = te_window_wait(ev.us_since_te);
         r.settle_delay_us = 16'(scale_to_rate(delay_before));
         r.flag_write      = (kind == CHG_COMMON_ADD);
         r.max_backlight   = (kind == CHG_COMMON_ADD);
         hbm_on            = 1'b1;
      end else if (hbm_on && kind == CHG_REMOVED) begin
         r.action          = ACT_EXIT;
         r.sync_delay_us   = te_window_wait(ev.us_since_te);
         r.settle_delay_us = 16'(scale_to_rate(delay_after));
         r.flag_write      = 1'b1;
         hbm_on            = 1'b0;
      end else if (kind == CHG_CIRCLE_ADD) begin
         r.action        = ACT_CIRCLE_ON;
         r.flag_write    = 1'b1;
         r.max_backlight = 1'b1;
      end else if (kind == CHG_CIRCLE_REMOVED) begin
         r.action     = ACT_CIRCLE_OFF;
         r.flag_write = 1'b1;
      end

      last_mask  = ev.mask_state;
      r.hbm_open = hbm_on;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         fps_mode        = FPS_60;
         left_thresh     = '0;
         right_thresh    = '0;
         te_period       = 16'(TE60);
         delay_before    = '0;
         delay_after     = '0;
         last_mask       = MASK_NONE;
         hbm_on          = 1'b0;
         screen_on_armed = 1'b0;
         end_reported    = 1'b0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FPS_MODE:     fps_mode     = csr_wdata[1:0];
               CSR_LEFT_THRESH:  left_thresh  = csr_wdata;
               CSR_RIGHT_THRESH: right_thresh = csr_wdata;
               CSR_TE_PERIOD:    te_period    = csr_wdata;
               CSR_DELAY_BEFORE: delay_before = csr_wdata;
               CSR_DELAY_AFTER:  delay_after  = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               flag_error("result word with no frame event pending");
            end else begin
               want = expected_results.pop_front();
               check_field("action", rsp_data.action, want.action);
               check_field("sync_delay_us", rsp_data.sync_delay_us, want.sync_delay_us);
               check_field("settle_delay_us", rsp_data.settle_delay_us, want.settle_delay_us);
               check_field("flag_write", rsp_data.flag_write, want.flag_write);
               check_field("max_backlight", rsp_data.max_backlight, want.max_backlight);
               check_field("hbm_open", rsp_data.hbm_open, want.hbm_open);
               checked++;
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(next_result(req_data));
         if (end_check && !end_reported) begin
            end_reported = 1'b1;
            if (expected_results.size() != 0)
               flag_error($sformatf("%0d result words never arrived", expected_results.size()));
         end
      end
      outstanding = expected_results.size();
   end

endmodule

// File: dv/tb_mask_layer_hbm_te_sync.sv
`timescale 1ns / 1ps
// Testbench top for mask_layer_hbm_te_sync: clock, reset, register writes and frame events
// under several idle mixes and one long result hold; verdict from mlhts_checker.
// Depends on mlhts_pkg, mlhts_checker and the block itself.
module tb_mask_layer_hbm_te_sync;
   import mlhts_pkg::*;

   localparam int PHASES        = 8;
   localparam int PHASE_EVENTS  = 206;
   localparam int BLOCK_LATENCY = 110;
   localparam int LONG_HOLD     = 600;
   localparam int MAX_GAP       = 50;
   localparam int LIMIT_CYCLES  = 1500000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [15:0]          csr_wdata;
   logic                 end_check;

   int check_errors;
   int pending_results;
   int results_checked;
   int cycle_count = 0;
   int events_sent = 0;
   int settings_used = 0;
   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   bit pressure_on = 1'b0;

   mask_layer_hbm_te_sync u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mlhts_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .end_check   (end_check),
      .errors      (check_errors),
      .outstanding (pending_results),
      .checked     (results_checked)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_results);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: random stall, or one long hold once pressure is requested.
   initial begin : rsp_side
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (pressure_on && !hold_done) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   function automatic req_type make_event(input mask_type mask, input logic [23:0] us,
                                          input logic bl, input logic arm);
      req_type ev;
      ev.mask_state       = mask;
      ev.us_since_te      = us;
      ev.backlight_active = bl;
      ev.arm_screen_on    = arm;
      return ev;
   endfunction

   function automatic req_type random_event();
      req_type ev;
      ev.mask_state = mask_type'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       ev.us_since_te = 24'($urandom);
         1:       ev.us_since_te = 24'($urandom_range(0, 70000));
         2:       ev.us_since_te = 24'($urandom_range(0, 400));
         default: ev.us_since_te = 24'($urandom_range(0, 255) * 16667 + $urandom_range(0, 40));
      endcase
      ev.backlight_active = ($urandom_range(0, 3) != 0);
      ev.arm_screen_on    = ($urandom_range(0, 3) == 0);
      return ev;
   endfunction

   function automatic logic [15:0] random_reg();
      if ($urandom_range(0, 2) == 0)
         return 16'($urandom);
      return 16'($urandom_range(0, 20000));
   endfunction

   task automatic send_event(input req_type ev);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < req_idle_pct)
         gap++;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= ev;
      do @(posedge clock); while (req_stall);
      events_sent++;
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_settings(input logic [1:0] fps, input logic [15:0] left_us,
                                 input logic [15:0] right_us, input logic [15:0] te_us,
                                 input logic [15:0] before_us, input logic [15:0] after_us);
      write_register(CSR_FPS_MODE, {14'($urandom), fps});
      write_register(CSR_LEFT_THRESH, left_us);
      write_register(CSR_RIGHT_THRESH, right_us);
      write_register(CSR_TE_PERIOD, te_us);
      write_register(CSR_DELAY_BEFORE, before_us);
      write_register(CSR_DELAY_AFTER, after_us);
      settings_used++;
   endtask

   // Drop valid, drain all results, then let the block settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(negedge clock);
      repeat (BLOCK_LATENCY) @(negedge clock);
   endtask

   initial begin : stimulus
      int phase;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_FPS_MODE;
      csr_wdata = '0;
      end_check = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      apply_settings(FPS_60, 16'd100, 16'd2000, 16'(TE60), 16'd500, 16'd800);
      send_event(make_event(MASK_COMMON, 24'd0, 1'b1, 1'b0));
      send_event(make_event(MASK_COMMON, 24'd50, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'hFFFFFF, 1'b0, 1'b0));
      send_event(make_event(MASK_NONE, 24'd0, 1'b0, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'd1000, 1'b1, 1'b1));
      send_event(make_event(MASK_CIRCLE, 24'd16666, 1'b1, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'd16667, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'd2000, 1'b0, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'd99, 1'b0, 1'b1));
      send_event(make_event(MASK_NONE, 24'd2001, 1'b0, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'd16767, 1'b1, 1'b0));
      send_event(make_event(MASK_CIRCLE, 24'd16766, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'd33333, 1'b1, 1'b0));
      send_event(make_event(MASK_CIRCLE, 24'd5, 1'b1, 1'b1));
      send_event(make_event(MASK_SCREEN_ON, 24'd100, 1'b1, 1'b0));
      send_event(make_event(MASK_CIRCLE, 24'd101, 1'b0, 1'b0));
      send_event(make_event(MASK_COMMON, 24'd7000, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'd8000, 1'b1, 1'b0));
      send_event(make_event(MASK_COMMON, 24'd16667005, 1'b1, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'd1, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'h800000, 1'b1, 1'b0));
      send_event(make_event(MASK_SCREEN_ON, 24'h7FFFFF, 1'b1, 1'b0));
      send_event(make_event(MASK_NONE, 24'd16000, 1'b0, 1'b0));

      for (phase = 1; phase <= PHASES; phase++) begin
         wait_drained();
         case (phase)
            1: apply_settings(FPS_120, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF);
            2: apply_settings(FPS_90, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
            3: apply_settings(2'd3, random_reg(), random_reg(), random_reg(), random_reg(),
                              random_reg());
            default: apply_settings(2'($urandom_range(0, 3)), random_reg(), random_reg(),
                                    random_reg(), random_reg(), random_reg());
         endcase
         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 76;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 76;
            end
            default: begin
               req_idle_pct  = 20;
               rsp_stall_pct = 20;
            end
         endcase
         if (phase == 4)
            pressure_on = 1'b1;
         repeat (PHASE_EVENTS) send_event(random_event());
      end

      wait_drained();
      end_check <= 1'b1;
      repeat (2) @(negedge clock);
      $display("summary: %0d frame events, %0d result words checked, %0d register settings",
               events_sent, results_checked, settings_used);
      $display("summary: idle mixes none/sender/receiver/both, one %0d-cycle result hold",
               LONG_HOLD);
      if (check_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
